[rtl/stable_softmax_unit_defines.svh]
// Assertion macros used by the softmax unit top.
// No dependencies; included by files that carry concurrent checks.
`ifndef STABLE_SOFTMAX_UNIT_DEFINES_SVH
`define STABLE_SOFTMAX_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssm_pkg.sv]
// Shared types and constants of the softmax unit.
// No dependencies; used by every RTL module by scoped names.
`default_nettype none
package ssm_pkg;

    // exp(-x) fixed-point constants, Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [19:0] C4_Q16    = 20'd630;
    localparam logic [19:0] ONE_Q16   = 20'd65536;
    // tq at and above which the shift count exceeds sixteen
    localparam int unsigned UFLOW_TQ  = 1081344;

    localparam int EXP_W  = 17;   // Q1.16 exponential
    localparam int PROB_W = 16;   // Q0.16 probability

    // Horner coefficients, in the order they are added
    function automatic logic [19:0] horner_coef(input logic [1:0] step);
        logic [19:0] c;
        case (step)
            2'd0:    c = 20'd3638;
            2'd1:    c = 20'd15743;
            2'd2:    c = 20'd45426;
            default: c = ONE_Q16;
        endcase
        return c;
    endfunction

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_GO,
        ST_EXP_WAIT,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

[rtl/stable_softmax_unit.sv]
// Softmax unit top: logit and exponential stores, sequencer, exp and
// divider units. Depends on ssm_pkg, ssm_exp, ssm_div and the defines header.
//
//  channel | beat fields                      | handshake
//  input   | i_logit, i_last                  | i_in_valid / o_in_ready
//  output  | o_prob, o_overflow, o_last_out   | o_out_valid / i_out_ready
//
// A non-final logit is taken in one cycle. After the final one each stored
// element goes through the exp pass (memory read, 7-phase exp unit)
// and then the divide pass (34-step divider) and the output wait.
// Reset is synchronous; the stores need no clearing pass.
// No input beat is taken while a vector is being emitted; the result
// register holds while the output side stalls.
`default_nettype none
`include "stable_softmax_unit_defines.svh"
module stable_softmax_unit #(
    parameter int MAX_LEN    = 64,
    parameter int LOGIT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [LOGIT_BITS-1:0] i_logit,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [15:0]                o_prob,
    output logic                       o_overflow,
    output logic                       o_last_out
);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1) > 0 ? $clog2(MAX_LEN + 1) : 1;
    localparam int A_W   = LOGIT_BITS + 1;
    localparam int SUM_W = ssm_pkg::EXP_W + $clog2(MAX_LEN);

    ssm_pkg::t_state r_state, n_state;

    logic [LOGIT_BITS-1:0]      logit_mem [MAX_LEN];
    logic [ssm_pkg::EXP_W-1:0]  exp_mem   [MAX_LEN];
    logic [LOGIT_BITS-1:0]      r_logit_rd;
    logic [ssm_pkg::EXP_W-1:0]  r_exp_rd;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_idx;
    logic signed [LOGIT_BITS-1:0] r_max;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_ovf;
    logic [15:0]                r_prob;
    logic                       r_last_out;

    logic in_beat, out_beat, is_last_idx;
    logic exp_start, exp_done, div_start, div_done;
    logic [ssm_pkg::EXP_W-1:0]  exp_val;
    logic [15:0]                div_prob;
    logic [A_W-1:0]             diff;

    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = o_out_valid && i_out_ready;
    assign is_last_idx = (r_idx == r_count - CNT_W'(1));
    assign diff        = {r_max[LOGIT_BITS-1], r_max} - {r_logit_rd[LOGIT_BITS-1], r_logit_rd};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssm_pkg::ST_LOAD:     if (in_beat && i_last) n_state = ssm_pkg::ST_EXP_RD;
            ssm_pkg::ST_EXP_RD:   n_state = ssm_pkg::ST_EXP_GO;
            ssm_pkg::ST_EXP_GO:   n_state = ssm_pkg::ST_EXP_WAIT;
            ssm_pkg::ST_EXP_WAIT: begin
                if (exp_done) n_state = is_last_idx ? ssm_pkg::ST_DIV_RD : ssm_pkg::ST_EXP_RD;
            end
            ssm_pkg::ST_DIV_RD:   n_state = ssm_pkg::ST_DIV_GO;
            ssm_pkg::ST_DIV_GO:   n_state = ssm_pkg::ST_DIV_WAIT;
            ssm_pkg::ST_DIV_WAIT: if (div_done) n_state = ssm_pkg::ST_OUT;
            ssm_pkg::ST_OUT: begin
                if (out_beat) n_state = r_last_out ? ssm_pkg::ST_LOAD : ssm_pkg::ST_DIV_RD;
            end
            default:              n_state = ssm_pkg::ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        exp_start   = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            ssm_pkg::ST_LOAD:   o_in_ready  = 1'b1;
            ssm_pkg::ST_EXP_GO: exp_start   = 1'b1;
            ssm_pkg::ST_DIV_GO: div_start   = 1'b1;
            ssm_pkg::ST_OUT:    o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::ST_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_max   <= {1'b1, {(LOGIT_BITS-1){1'b0}}};
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            // load: store, track maximum, flag overflow
            if (in_beat) begin
                if (r_count < CNT_W'(MAX_LEN)) begin
                    r_count <= r_count + CNT_W'(1);
                    if (signed'(i_logit) > r_max) r_max <= signed'(i_logit);
                end else begin
                    r_ovf <= 1'b1;
                end
                r_idx <= '0;
            end
            // accumulate and advance through the exp pass
            if (r_state == ssm_pkg::ST_EXP_WAIT && exp_done) begin
                r_sum <= r_sum + SUM_W'(exp_val);
                r_idx <= is_last_idx ? '0 : r_idx + CNT_W'(1);
            end
            // advance or drop the vector after each output beat
            if (out_beat) begin
                if (r_last_out) begin
                    r_count <= '0;
                    r_idx   <= '0;
                    r_max   <= {1'b1, {(LOGIT_BITS-1){1'b0}}};
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
        end
    end

    // logit store: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (in_beat && r_count < CNT_W'(MAX_LEN)) begin
            logit_mem[r_count[IDX_W-1:0]] <= i_logit;
        end
        r_logit_rd <= logit_mem[r_idx[IDX_W-1:0]];
    end

    // exponential store: write after exp, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::ST_EXP_WAIT && exp_done) begin
            exp_mem[r_idx[IDX_W-1:0]] <= exp_val;
        end
        r_exp_rd <= exp_mem[r_idx[IDX_W-1:0]];
    end

    // hold the result beat
    always_ff @(posedge i_clk) begin
        if (r_state == ssm_pkg::ST_DIV_WAIT && div_done) begin
            r_prob     <= div_prob;
            r_last_out <= is_last_idx;
        end
    end

    ssm_exp #(.A_W(A_W)) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_a     (diff),
        .o_done  (exp_done),
        .o_exp   (exp_val)
    );

    ssm_div #(.SUM_W(SUM_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_exp   (r_exp_rd),
        .i_sum   (r_sum),
        .o_done  (div_done),
        .o_prob  (div_prob)
    );

    assign o_prob     = r_prob;
    assign o_overflow = r_ovf;
    assign o_last_out = r_last_out;

    `SSM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid, "input taken during output")
    `SSM_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LEN), "count past depth")
    `SSM_ASSERT_NEXT(a_clear_after, i_clk, i_rst_n, out_beat && o_last_out, r_count == '0 && !r_ovf, "state not cleared")
    `SSM_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, o_out_valid, r_idx < r_count, "index past count")
endmodule
`default_nettype wire

[rtl/ssm_exp.sv]
// Multi-cycle exp(-a/256) unit: log2(e) scaling, split into n and f,
// Horner polynomial for 2^f, shift by n. Depends on ssm_pkg.
`default_nettype none
module ssm_exp #(
    parameter int A_W = 17
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [A_W-1:0]             i_a,
    output logic                            o_done,
    output logic [ssm_pkg::EXP_W-1:0]       o_exp
);
    localparam int TQ_W  = A_W + 9;
    localparam int TQX_W = (TQ_W > 21) ? TQ_W + 1 : 22;

    logic              r_busy, n_busy;
    logic [2:0]        r_ph, n_ph;
    logic [A_W-1:0]    r_a;
    logic [TQ_W-1:0]   r_tq;
    logic [4:0]        r_n;
    logic              r_uf;
    logic signed [17:0] r_f;
    logic signed [19:0] r_acc;
    logic              r_done;
    logic [ssm_pkg::EXP_W-1:0] r_exp;

    logic [A_W+16:0]   prod_tq;
    logic [TQX_W-1:0]  tqx;
    logic [TQX_W-1:0]  tq_rnd;
    logic [21:0]       f_full;
    logic signed [37:0] prod_h;
    logic [37:0]       prod_abs;
    logic [21:0]       rnd_mag;
    logic signed [19:0] rnd_val;
    logic [19:0]       acc_pos;
    logic [19:0]       shifted;

    // scale by log2(e), round to Q16
    assign prod_tq = TQ_W'(0) + (A_W+17)'(r_a) * (A_W+17)'(ssm_pkg::LOG2E_Q16);
    assign tqx     = TQX_W'(r_tq);
    assign tq_rnd  = tqx + TQX_W'(32768);
    assign f_full  = {1'b0, tq_rnd[20:16], 16'd0} - tqx[21:0];

    // Horner step product, rounded half away from zero
    assign prod_h   = 38'(r_f) * 38'(r_acc);
    assign prod_abs = prod_h[37] ? 38'(-prod_h) : 38'(prod_h);
    assign rnd_mag  = 22'((prod_abs + 38'd32768) >> 16);
    assign rnd_val  = prod_h[37] ? -20'(signed'(rnd_mag[19:0])) : 20'(signed'(rnd_mag[19:0]));

    assign acc_pos = r_acc[19] ? 20'd0 : 20'(r_acc);
    assign shifted = acc_pos >> r_n;

    // advance the phase counter
    always_comb begin
        n_busy = r_busy;
        n_ph   = r_ph;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_ph   = 3'd0;
            end
        end else if (r_ph == 3'd6) begin
            n_busy = 1'b0;
        end else begin
            n_ph = r_ph + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ph   <= n_ph;
            r_done <= r_busy && (r_ph == 3'd6);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_a <= i_a;
        end
        if (r_busy) begin
            case (r_ph)
                3'd0: r_tq <= TQ_W'((prod_tq + (A_W+17)'(128)) >> 8);
                3'd1: begin
                    r_uf  <= (tqx >= TQX_W'(ssm_pkg::UFLOW_TQ));
                    r_n   <= tq_rnd[20:16];
                    r_f   <= signed'(f_full[17:0]);
                    r_acc <= signed'(ssm_pkg::C4_Q16);
                end
                3'd2, 3'd3, 3'd4, 3'd5: begin
                    r_acc <= signed'(ssm_pkg::horner_coef(2'(r_ph - 3'd2))) + rnd_val;
                end
                default: r_exp <= r_uf ? '0 : shifted[ssm_pkg::EXP_W-1:0];
            endcase
        end
    end

    assign o_done = r_done;
    assign o_exp  = r_exp;
endmodule
`default_nettype wire

[rtl/ssm_div.sv]
// Restoring divider, one quotient bit a cycle, rounded and saturated
// to Q0.16. Depends on ssm_pkg.
`default_nettype none
module ssm_div #(
    parameter int SUM_W = 23
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ssm_pkg::EXP_W-1:0]   i_exp,
    input  wire logic [SUM_W-1:0]            i_sum,
    output logic                             o_done,
    output logic [ssm_pkg::PROB_W-1:0]       o_prob
);
    localparam int NUM_W = ssm_pkg::EXP_W + 17;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [SUM_W-1:0]   r_den;
    logic [SUM_W:0]     r_rem;
    logic               r_done;

    logic [SUM_W-1:0]   den;
    logic [SUM_W:0]     trial;
    logic               fits;

    assign den   = (i_sum == '0) ? SUM_W'(1) : i_sum;
    assign trial = {r_rem[SUM_W-1:0], r_num[NUM_W-1]};
    assign fits  = trial >= (SUM_W+1)'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift in numerator bits; quotient replaces them from the bottom
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_num <= {i_exp, 16'd0} + NUM_W'(den >> 1);
            r_den <= den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial - (SUM_W+1)'(r_den) : trial;
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_prob = (r_num[NUM_W-1:16] != '0) ? '1 : r_num[15:0];
endmodule
`default_nettype wire
